[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and held off during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dwm_pkg.sv]
// Types, constants and output helper for the wheel mixer.
package dwm_pkg;

  // config register indexes
  localparam logic [7:0] REG_MAX_SPEED    = 8'd0;
  localparam logic [7:0] REG_MAX_YAW_RATE = 8'd1;
  localparam logic [7:0] REG_WHEEL_BASE   = 8'd2;
  localparam logic [7:0] REG_TIMEOUT_US   = 8'd3;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [14:0] MAX_SPEED_RST    = 15'd256;
  localparam logic [14:0] MAX_YAW_RATE_RST = 15'd256;
  localparam logic [14:0] WHEEL_BASE_RST   = 15'd128;
  localparam logic [23:0] TIMEOUT_US_RST   = 24'd100000;

  // wheel-term width: holds +/-(2^21 + 2^21) with margin
  localparam int WW = 26;
  // quotient bits below the saturation point
  localparam int QW = 15;

  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QW / DIV_STEPS;

  // pipeline map: clamp, mult, rot, excess, wheels, abs, divider stages, output
  localparam int ST_DIV0  = 6;
  localparam int ST_OUT   = ST_DIV0 + DIV_STAGES;
  localparam int STAGES   = ST_OUT + 1;

  localparam logic signed [15:0] DRIVE_MAX = 16'sh7fff;
  localparam logic signed [15:0] DRIVE_MIN = 16'sh8000;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [QW-1:0] rem;
    logic [QW-1:0] q;
  } div_lane_t;

  // Sign, saturate and gate one lane's quotient.
  function automatic logic signed [15:0] drive_of(input div_lane_t l, input logic z);
    logic signed [15:0] r;
    if (z) begin
      r = '0;
    end else if (l.big) begin
      r = l.neg ? DRIVE_MIN : DRIVE_MAX;
    end else if (l.neg) begin
      r = -signed'({1'b0, l.q});
    end else begin
      r = signed'({1'b0, l.q});
    end
    return r;
  endfunction

endpackage

[rtl/diff_drive_wheel_mixer.sv]
// Differential-drive wheel mixer: pipelined top level.
//
// Input channel: in_valid / in_stall, one command beat per cycle while in_stall is low, carrying
// speed_cmd, turn_rate_cmd, setpoint_time_us, now_time_us and armed_flag.
// Output channel: out_valid / out_stall, one beat of left_drive and
// right_drive (Q1.15) per input beat, in order.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// max_speed (0), max_yaw_rate (1), wheel_base (2), timeout_us (3); other
// indexes are dropped. Write only while the pipeline is empty.
// An accepted beat passes stages A to F, the divider stages and the output stage.
// Throughput: one beat per cycle while out_stall is low; the 12 register
// stages each take a new beat whenever they advance. The quotient is built
// by a restoring divider spread over 5 stages, 3 quotient bits per stage.
// Stall: each stage advances when it is empty or its successor advances, so
// bubbles are squeezed out; in_stall rises only when all stages hold data
// and out_stall is high. Nothing is dropped or repeated.
// Reset: rst (synchronous) empties the pipeline and loads the register
// defaults 256, 256, 128 and 100000.
module diff_drive_wheel_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 speed_cmd,
  input  logic signed [15:0]                 turn_rate_cmd,
  input  logic [63:0]                        setpoint_time_us,
  input  logic [63:0]                        now_time_us,
  input  logic                               armed_flag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 left_drive,
  output logic signed [15:0]                 right_drive,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dwm_pkg::*;

  `include "assert_macros.svh"

  logic [14:0] max_speed;
  logic [14:0] max_yaw_rate;
  logic [14:0] wheel_base;
  logic [23:0] timeout_us;

  logic [STAGES-1:0] v;
  logic [STAGES:0]   move;

  // stage A: gating and clamps
  logic               a_zero;
  logic signed [15:0] a_lin;
  logic signed [15:0] a_yaw;
  // stage B: product
  logic               b_zero;
  logic signed [15:0] b_lin;
  logic signed [31:0] b_prod;
  // stage C: rotational term and magnitudes
  logic                 c_zero;
  logic signed [15:0]   c_lin;
  logic [15:0]          c_alin;
  logic signed [WW-1:0] c_rot;
  logic [WW-1:0]        c_arot;
  // stage D: limited linear term
  logic                 d_zero;
  logic signed [WW-1:0] d_lin;
  logic signed [WW-1:0] d_rot;
  // stage E: wheel terms
  logic                 e_zero;
  logic signed [WW-1:0] e_wl;
  logic signed [WW-1:0] e_wr;
  // stage F and divider stages
  logic                 f_zero;
  div_lane_t            f_lane [2];
  logic                 dz [DIV_STAGES];
  div_lane_t            dv [DIV_STAGES][2];
  div_lane_t            dv_next [DIV_STAGES][2];

  logic [64:0]          deadline;
  logic                 stale;
  logic signed [15:0]   ms_s;
  logic signed [15:0]   yr_s;
  logic signed [15:0]   lin_a;
  logic signed [15:0]   yaw_a;
  logic signed [WW-1:0] rot_c;
  logic                 excess;
  logic signed [WW-1:0] mag_d;
  logic signed [WW-1:0] lin_d;
  div_lane_t            lane_f [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= MAX_SPEED_RST;
      max_yaw_rate <= MAX_YAW_RATE_RST;
      wheel_base   <= WHEEL_BASE_RST;
      timeout_us   <= TIMEOUT_US_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_SPEED:    max_speed    <= cfg_data[14:0];
        REG_MAX_YAW_RATE: max_yaw_rate <= cfg_data[14:0];
        REG_WHEEL_BASE:   wheel_base   <= cfg_data[14:0];
        REG_TIMEOUT_US:   timeout_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when its successor moves on
  always_comb begin
    move[STAGES] = !out_stall;
    for (int k = STAGES - 1; k >= 0; k--) begin
      move[k] = !v[k] || move[k+1];
    end
  end

  assign in_stall = !move[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (move[0]) v[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (move[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage A logic
  always_comb begin
    // stale when now > setpoint + timeout, summed without wrap
    deadline = {1'b0, setpoint_time_us} + 65'(timeout_us);
    stale    = {1'b0, now_time_us} > deadline;
    ms_s     = signed'({1'b0, max_speed});
    yr_s     = signed'({1'b0, max_yaw_rate});
    if (speed_cmd > ms_s)       lin_a = ms_s;
    else if (speed_cmd < -ms_s) lin_a = -ms_s;
    else                        lin_a = speed_cmd;
    if (turn_rate_cmd > yr_s)       yaw_a = yr_s;
    else if (turn_rate_cmd < -yr_s) yaw_a = -yr_s;
    else                            yaw_a = turn_rate_cmd;
  end

  // stage C logic: floor shift matches the arithmetic shift of the product
  assign rot_c = WW'(b_prod >>> 9);

  // stage D logic
  always_comb begin
    excess = (WW'(c_alin) + c_arot) > WW'(max_speed);
    mag_d  = signed'(WW'(max_speed)) - signed'(c_arot);
    if (!excess)        lin_d = WW'(c_lin);
    else if (c_lin > 0) lin_d = mag_d;
    else if (c_lin < 0) lin_d = -mag_d;
    else                lin_d = '0;
  end

  // stage F logic: |w| >= max_speed means the quotient saturates
  always_comb begin
    logic [WW-1:0] aw [2];
    aw[0] = (e_wl < 0) ? WW'(-e_wl) : WW'(e_wl);
    aw[1] = (e_wr < 0) ? WW'(-e_wr) : WW'(e_wr);
    lane_f[0].neg = e_wl < 0;
    lane_f[1].neg = e_wr < 0;
    for (int l = 0; l < 2; l++) begin
      lane_f[l].big = aw[l] >= WW'(max_speed);
      lane_f[l].rem = aw[l][QW-1:0];
      lane_f[l].q   = '0;
    end
  end

  // restoring divider: remainder stays below max_speed on lanes that do not saturate
  always_comb begin
    div_lane_t     t;
    logic [QW:0]   r2;
    for (int j = 0; j < DIV_STAGES; j++) begin
      for (int l = 0; l < 2; l++) begin
        t = (j == 0) ? f_lane[l] : dv[(j == 0) ? 0 : j-1][l];
        for (int s = 0; s < DIV_STEPS; s++) begin
          r2 = {t.rem, 1'b0};
          if (r2 >= {1'b0, max_speed}) begin
            t.rem = QW'(r2 - {1'b0, max_speed});
            t.q   = {t.q[QW-2:0], 1'b1};
          end else begin
            t.rem = r2[QW-1:0];
            t.q   = {t.q[QW-2:0], 1'b0};
          end
        end
        dv_next[j][l] = t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      a_zero <= (max_speed == '0) || !armed_flag || stale;
      a_lin  <= lin_a;
      a_yaw  <= yaw_a;
    end
    if (move[1]) begin
      b_zero <= a_zero;
      b_lin  <= a_lin;
      b_prod <= signed'({1'b0, wheel_base}) * a_yaw;
    end
    if (move[2]) begin
      c_zero <= b_zero;
      c_lin  <= b_lin;
      c_alin <= (b_lin < 0) ? 16'(-b_lin) : 16'(b_lin);
      c_rot  <= rot_c;
      c_arot <= (rot_c < 0) ? WW'(-rot_c) : WW'(rot_c);
    end
    if (move[3]) begin
      d_zero <= c_zero;
      d_lin  <= lin_d;
      d_rot  <= c_rot;
    end
    if (move[4]) begin
      e_zero <= d_zero;
      e_wl   <= d_lin - d_rot;
      e_wr   <= d_lin + d_rot;
    end
    if (move[5]) begin
      f_zero <= e_zero;
      f_lane <= lane_f;
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (move[ST_DIV0+j]) begin
        dz[j] <= (j == 0) ? f_zero : dz[(j == 0) ? 0 : j-1];
        dv[j] <= dv_next[j];
      end
    end
    if (move[ST_OUT]) begin
      left_drive  <= drive_of(dv[DIV_STAGES-1][0], dz[DIV_STAGES-1]);
      right_drive <= drive_of(dv[DIV_STAGES-1][1], dz[DIV_STAGES-1]);
    end
  end

  assign out_valid = v[ST_OUT];

  `ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, v[0], "accepted beat not captured")
  `ASSERT_IMPL(a_stall_full, in_stall, &v, "input stalled with an empty stage")
  // saturating lanes carry a truncated remainder, so only the others are checked
  `ASSERT_IMPL(a_div_rem, v[ST_OUT-1] && !dz[DIV_STAGES-1],
    (dv[DIV_STAGES-1][0].big || (dv[DIV_STAGES-1][0].rem < max_speed)) &&
    (dv[DIV_STAGES-1][1].big || (dv[DIV_STAGES-1][1].rem < max_speed)),
    "divider remainder out of range")

endmodule
